// ----- rtl/min_max_heap_priority_queue_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the min-max heap priority queue.
// Each macro expands to a concurrent assertion, or to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef MIN_MAX_HEAP_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define MIN_MAX_HEAP_PRIORITY_QUEUE_TOP_ASSERT_SVH
`ifndef SYNTH
`define MMH_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define MMH_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MMH_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define MMH_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- rtl/mmh_pkg.sv -----
// ----------------------------------------------------------------------------
// Min-max heap package
// Shared widths, codes and memory port types of the heap priority queue.
// ----------------------------------------------------------------------------
package mmh_pkg;
  localparam int unsigned Capacity = 1024;
  localparam int unsigned AddrW = $clog2(Capacity);
  localparam int unsigned CntW = $clog2(Capacity + 1);

  localparam logic [1:0] CmdInsert = 2'd0;
  localparam logic [1:0] CmdRemMax = 2'd1;

  localparam logic [2:0] StInserted = 3'd0;
  localparam logic [2:0] StMaxRemoved = 3'd1;
  localparam logic [2:0] StMinRemoved = 3'd2;
  localparam logic [2:0] StEmpty = 3'd3;
  localparam logic [2:0] StFull = 3'd4;

  typedef struct packed {
    logic [31:0] job;
    logic signed [31:0] prio;
  } slot_t;

  typedef struct packed {
    logic rd_en;
    logic [AddrW-1:0] rd_addr;
    logic wr_en;
    logic [AddrW-1:0] wr_addr;
    slot_t wr_data;
  } mem_req_t;
endpackage

// ----- rtl/min_max_heap_priority_queue_top.sv -----
// ----------------------------------------------------------------------------
// Min-max heap priority queue
// A command that finds the queue empty or full goes straight to its result.
// An insert bubbles up past its parent and then its grandparents. A removal
// runs trickle-down steps; a step moves the entry to its best child or
// grandchild and reads the six children and grandchildren one per cycle
// through the single read port of the heap RAM.
// Results wait in an output register, and the next command is taken once the
// current one has left the sequencer and the output register is free or being
// read.
// ----------------------------------------------------------------------------
`include "min_max_heap_priority_queue_top_assert.svh"
module min_max_heap_priority_queue_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // cmd[1:0], job_id[33:2], priority_req[65:34]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata   // status[2:0], out_job_id[34:3],
                                     // out_priority[66:35], entry_total[77:67]
);
  logic busy, done;
  logic [2:0] status;
  mmh_pkg::slot_t out_slot;
  logic [mmh_pkg::CntW-1:0] count;
  mmh_pkg::mem_req_t mem;
  mmh_pkg::slot_t rd_data;
  logic ov_q;
  logic [79:0] od_q;
  logic start;

  assign s_axis_tready = !busy && (!ov_q || m_axis_tready);
  assign start = s_axis_tvalid && s_axis_tready;

  mmh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .cmd_i      (s_axis_tdata[1:0]),
    .job_i      (s_axis_tdata[33:2]),
    .prio_i     (s_axis_tdata[65:34]),
    .busy_o     (busy),
    .done_o     (done),
    .status_o   (status),
    .out_slot_o (out_slot),
    .count_o    (count),
    .mem_o      (mem),
    .rd_data_i  (rd_data)
  );

  mmh_ram u_ram (
    .clk_i     (clk_i),
    .req_i     (mem),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (done) begin
      ov_q <= 1'b1;
    end else if (m_axis_tready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      od_q <= {2'b0, count, out_slot.prio, out_slot.job, status};
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata = od_q;

  `MMH_ASSERT_IMP(a_no_start_busy, clk_i, rst_ni, busy, !s_axis_tready)
  `MMH_ASSERT_IMP(a_count_range, clk_i, rst_ni, 1'b1, count <= mmh_pkg::CntW'(mmh_pkg::Capacity))
  `MMH_ASSERT_NXT(a_done_valid, clk_i, rst_ni, done, m_axis_tvalid)
endmodule

// ----- rtl/mmh_ram.sv -----
// ----------------------------------------------------------------------------
// Min-max heap store
// Single-port-write, single-port-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module mmh_ram (
  input  logic              clk_i,
  input  mmh_pkg::mem_req_t req_i,
  output mmh_pkg::slot_t    rd_data_o
);
  mmh_pkg::slot_t mem_q [mmh_pkg::Capacity];
  mmh_pkg::slot_t rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_q;
endmodule

// ----- rtl/mmh_ctrl.sv -----
// ----------------------------------------------------------------------------
// Min-max heap sequencer
// Walks the heap one entry access per cycle for insert, bubble-up and
// trickle-down, and produces one result word per command.
// ----------------------------------------------------------------------------
module mmh_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [1:0]                    cmd_i,
  input  logic [31:0]                   job_i,
  input  logic [31:0]                   prio_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic [2:0]                    status_o,
  output mmh_pkg::slot_t                out_slot_o,
  output logic [mmh_pkg::CntW-1:0]      count_o,
  output mmh_pkg::mem_req_t             mem_o,
  input  mmh_pkg::slot_t                rd_data_i
);
  localparam int unsigned AW = mmh_pkg::AddrW;
  localparam int unsigned CW = mmh_pkg::CntW;
  localparam int unsigned XW = AW + 3;

  localparam logic [4:0] SIdle = 5'd0;
  localparam logic [4:0] SUpChk = 5'd2;
  localparam logic [4:0] SGpRd = 5'd3;
  localparam logic [4:0] SGpChk = 5'd4;
  localparam logic [4:0] SRmRd1 = 5'd5;
  localparam logic [4:0] SRmRd2 = 5'd6;
  localparam logic [4:0] SRmSel = 5'd7;
  localparam logic [4:0] SRmHole = 5'd8;
  localparam logic [4:0] SRmLast = 5'd9;
  localparam logic [4:0] STdRd = 5'd10;
  localparam logic [4:0] STdCand = 5'd11;
  localparam logic [4:0] STdDec = 5'd12;
  localparam logic [4:0] STdPar = 5'd13;
  localparam logic [4:0] STdParChk = 5'd14;
  localparam logic [4:0] SDone = 5'd15;

  logic [4:0] state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [XW-1:0] best_q, best_d;
  logic [2:0] k_q, k_d;
  logic found_q, found_d;
  logic mn_q, mn_d;
  mmh_pkg::slot_t cur_q, cur_d;
  mmh_pkg::slot_t bst_q, bst_d;
  mmh_pkg::slot_t tmp_q, tmp_d;
  logic [2:0] status_q, status_d;
  mmh_pkg::slot_t out_q, out_d;
  mmh_pkg::mem_req_t mem;

  function automatic logic min_level(input logic [AW-1:0] i);
    logic [AW:0] v;
    logic par;
    v = {1'b0, i} + 1'b1;
    par = 1'b0;
    for (int b = 0; b <= AW; b++) begin
      if (v[b]) begin
        par = (b % 2) == 0;
      end
    end
    return par;
  endfunction

  function automatic logic beats(input logic signed [31:0] a,
                                 input logic signed [31:0] b, input logic mn);
    return mn ? (a < b) : (a > b);
  endfunction

  logic [XW-1:0] cand;
  logic [AW-1:0] gp_idx;
  logic [AW-1:0] par_idx;
  logic [XW-1:0] c4;
  assign c4 = {3'b0, idx_q} << 2;
  assign cand = (k_q < 3'd2) ? ({2'b0, idx_q, 1'b0} + XW'(1) + XW'(k_q))
                             : (c4 + XW'(3) + XW'(k_q) - XW'(2));
  assign gp_idx = AW'((idx_q - AW'(3)) >> 2);
  assign par_idx = AW'((best_q - XW'(1)) >> 1);

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    idx_d = idx_q;
    best_d = best_q;
    k_d = k_q;
    found_d = found_q;
    mn_d = mn_q;
    cur_d = cur_q;
    bst_d = bst_q;
    tmp_d = tmp_q;
    status_d = status_q;
    out_d = out_q;
    mem = '0;
    case (state_q)
      SIdle: begin
        if (start_i) begin
          out_d = '0;
          if (cmd_i == mmh_pkg::CmdInsert) begin
            if (cnt_q >= CW'(mmh_pkg::Capacity)) begin
              status_d = mmh_pkg::StFull;
              state_d = SDone;
            end else begin
              status_d = mmh_pkg::StInserted;
              cur_d.job = job_i;
              cur_d.prio = prio_i;
              idx_d = AW'(cnt_q);
              cnt_d = cnt_q + 1'b1;
              if (cnt_q == '0) begin
                mem.wr_en = 1'b1;
                mem.wr_addr = '0;
                mem.wr_data = {job_i, prio_i};
                state_d = SDone;
              end else begin
                mem.rd_en = 1'b1;
                mem.rd_addr = AW'((cnt_q - 1'b1) >> 1);
                state_d = SUpChk;
              end
            end
          end else if (cnt_q == '0) begin
            status_d = mmh_pkg::StEmpty;
            state_d = SDone;
          end else begin
            cnt_d = cnt_q - 1'b1;
            if (cmd_i == mmh_pkg::CmdRemMax) begin
              status_d = mmh_pkg::StMaxRemoved;
              if (cnt_q < CW'(3)) begin
                idx_d = AW'(cnt_q - 1'b1);
                mem.rd_en = 1'b1;
                mem.rd_addr = AW'(cnt_q - 1'b1);
                state_d = SRmHole;
              end else begin
                mem.rd_en = 1'b1;
                mem.rd_addr = AW'(1);
                state_d = SRmRd1;
              end
            end else begin
              status_d = mmh_pkg::StMinRemoved;
              idx_d = '0;
              mem.rd_en = 1'b1;
              mem.rd_addr = '0;
              state_d = SRmHole;
            end
          end
        end
      end
      SUpChk: begin
        mn_d = min_level(idx_q);
        if (beats(cur_q.prio, rd_data_i.prio, !min_level(idx_q))) begin
          mem.wr_en = 1'b1;
          mem.wr_addr = idx_q;
          mem.wr_data = rd_data_i;
          idx_d = AW'((idx_q - 1'b1) >> 1);
          mn_d = !min_level(idx_q);
        end
        state_d = SGpRd;
      end
      SGpRd: begin
        if (idx_q > AW'(2)) begin
          mem.rd_en = 1'b1;
          mem.rd_addr = gp_idx;
          state_d = SGpChk;
        end else begin
          mem.wr_en = 1'b1;
          mem.wr_addr = idx_q;
          mem.wr_data = cur_q;
          state_d = SDone;
        end
      end
      SGpChk: begin
        if (beats(cur_q.prio, rd_data_i.prio, mn_q)) begin
          mem.wr_en = 1'b1;
          mem.wr_addr = idx_q;
          mem.wr_data = rd_data_i;
          idx_d = gp_idx;
          state_d = SGpRd;
        end else begin
          mem.wr_en = 1'b1;
          mem.wr_addr = idx_q;
          mem.wr_data = cur_q;
          state_d = SDone;
        end
      end
      SRmRd1: begin
        tmp_d = rd_data_i;
        mem.rd_en = 1'b1;
        mem.rd_addr = AW'(2);
        state_d = SRmRd2;
      end
      SRmRd2: begin
        state_d = SRmSel;
      end
      SRmSel: begin
        if (tmp_q.prio > rd_data_i.prio) begin
          idx_d = AW'(1);
          out_d = tmp_q;
        end else begin
          idx_d = AW'(2);
          out_d = rd_data_i;
        end
        mem.rd_en = 1'b1;
        mem.rd_addr = AW'(cnt_q);
        state_d = SRmLast;
      end
      SRmHole: begin
        out_d = rd_data_i;
        mem.rd_en = 1'b1;
        mem.rd_addr = AW'(cnt_q);
        state_d = SRmLast;
      end
      SRmLast: begin
        cur_d = rd_data_i;
        if (CW'(idx_q) == cnt_q) begin
          state_d = SDone;
        end else begin
          mem.wr_en = 1'b1;
          mem.wr_addr = idx_q;
          mem.wr_data = rd_data_i;
          state_d = STdRd;
        end
      end
      STdRd: begin
        mn_d = min_level(idx_q);
        k_d = '0;
        found_d = 1'b0;
        if (({2'b0, idx_q, 1'b0} + XW'(1)) < XW'(cnt_q)) begin
          mem.rd_en = 1'b1;
          mem.rd_addr = AW'({2'b0, idx_q, 1'b0} + XW'(1));
          k_d = 3'd1;
          state_d = STdCand;
        end else begin
          state_d = SDone;
        end
      end
      STdCand: begin
        if (!found_q || beats(rd_data_i.prio, bst_q.prio, mn_q)) begin
          bst_d = rd_data_i;
          best_d = (k_q < 3'd3) ? ({2'b0, idx_q, 1'b0} + XW'(k_q))
                                : (cand - XW'(1));
        end
        found_d = 1'b1;
        if (k_q < 3'd6 && cand < XW'(cnt_q)) begin
          mem.rd_en = 1'b1;
          mem.rd_addr = AW'(cand);
          k_d = k_q + 1'b1;
        end else begin
          state_d = STdDec;
        end
      end
      STdDec: begin
        if (!beats(bst_q.prio, cur_q.prio, mn_q)) begin
          state_d = SDone;
        end else begin
          mem.wr_en = 1'b1;
          mem.wr_addr = idx_q;
          mem.wr_data = bst_q;
          if (best_q < c4 + XW'(3)) begin
            state_d = STdPar;
            idx_d = AW'(best_q);
          end else begin
            state_d = STdPar;
          end
        end
      end
      STdPar: begin
        if (best_q < c4 + XW'(3) && idx_q == AW'(best_q)) begin
          mem.wr_en = 1'b1;
          mem.wr_addr = idx_q;
          mem.wr_data = cur_q;
          state_d = SDone;
        end else begin
          mem.rd_en = 1'b1;
          mem.rd_addr = par_idx;
          state_d = STdParChk;
        end
      end
      STdParChk: begin
        idx_d = AW'(best_q);
        mem.wr_en = 1'b1;
        mem.wr_data = cur_q;
        if (beats(rd_data_i.prio, cur_q.prio, mn_q)) begin
          mem.wr_addr = par_idx;
          cur_d = rd_data_i;
        end else begin
          mem.wr_addr = AW'(best_q);
        end
        state_d = STdRd;
      end
      SDone: begin
        state_d = SIdle;
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // The slot at idx_q keeps the carried entry in cur_q; write it on exit.
  mmh_pkg::mem_req_t mem_fix;
  always_comb begin
    mem_fix = mem;
    if (state_q == STdRd && !(({2'b0, idx_q, 1'b0} + XW'(1)) < XW'(cnt_q))) begin
      mem_fix.wr_en = 1'b1;
      mem_fix.wr_addr = idx_q;
      mem_fix.wr_data = cur_q;
    end
    if (state_q == STdDec && !beats(bst_q.prio, cur_q.prio, mn_q)) begin
      mem_fix.wr_en = 1'b1;
      mem_fix.wr_addr = idx_q;
      mem_fix.wr_data = cur_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    best_q <= best_d;
    k_q <= k_d;
    found_q <= found_d;
    mn_q <= mn_d;
    cur_q <= cur_d;
    bst_q <= bst_d;
    tmp_q <= tmp_d;
    status_q <= status_d;
    out_q <= out_d;
  end

  assign busy_o = state_q != SIdle;
  assign done_o = state_q == SDone;
  assign status_o = status_q;
  assign out_slot_o = out_q;
  assign count_o = cnt_q;
  assign mem_o = mem_fix;
endmodule
